### sv/assert_macros.svh
// Assertion macros shared by the window unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property that must hold at every clock edge outside reset.
`define SRSW_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Condition that must be followed by a consequence in the next cycle.
`define SRSW_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define SRSW_ASSERT(lbl, clk, rstn, prop, msg)
`define SRSW_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

### sv/srsw_pkg.sv
// Types and constants of the selective repeat sender window unit.
package srsw_pkg;

  localparam int PKT_W      = 16;
  localparam int FRAME_W    = 16;
  localparam int WIN_CFG_W  = 7;
  localparam int TOTAL_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic MODE_START = 1'b0;
  localparam logic MODE_ACK   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_PACKETS = 2'd1;

  localparam logic [WIN_CFG_W-1:0] WINDOW_SIZE_RST   = 7'd4;
  localparam logic [TOTAL_W-1:0]   TOTAL_PACKETS_RST = 16'd0;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;       // clear session counters
    logic ack_rd;      // latch ack flags, read entry at read position
    logic ack_upd;     // compact a NAKed entry, advance read position
    logic frame_end;   // bump the frame counter
    logic refill_wr;   // write a fresh sequence number
    logic frame_load;  // commit frame size, start readout
    logic emit;        // load a packet result
    logic close;       // load the finished result, close session
  } srsw_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic session_open;
    logic ack_end;
    logic ack_close;
    logic refill_more;
    logic refill_empty;
    logic emit_last;
    logic out_free;
  } srsw_sts_t;

endpackage

### sv/srsw_if.sv
// Handshake channel interfaces: ack input, result output, configuration write.
interface srsw_in_if;
  logic valid;
  logic ready;
  logic mode;
  logic nak;
  logic last_entry;

  modport source (output valid, output mode, output nak, output last_entry, input ready);
  modport sink   (input valid, input mode, input nak, input last_entry, output ready);
endinterface

interface srsw_out_if;
  import srsw_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [PKT_W-1:0]     packet_number;
  logic [FRAME_W-1:0]   frame_number;
  logic                 last_of_frame;
  logic                 finished;

  modport source (output valid, output packet_number, output frame_number,
                  output last_of_frame, output finished, input ready);
  modport sink   (input valid, input packet_number, input frame_number,
                  input last_of_frame, input finished, output ready);
endinterface

interface srsw_cfg_if;
  import srsw_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### sv/srsw_datapath.sv
// Datapath: config registers, frame buffer memory, counters and result register.
module srsw_datapath #(
  parameter int MAX_WINDOW = 64,
  parameter int SEQ_WIDTH  = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [srsw_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [srsw_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             nak_i,
  input  logic                             last_i,
  input  srsw_pkg::srsw_cmd_t              cmd_i,
  output srsw_pkg::srsw_sts_t              sts_o,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic [srsw_pkg::PKT_W-1:0]       out_packet_number_o,
  output logic [srsw_pkg::FRAME_W-1:0]     out_frame_number_o,
  output logic                             out_last_of_frame_o,
  output logic                             out_finished_o
);
  import srsw_pkg::*;

  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int ADDR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int WIN_W  = (CNT_W > WIN_CFG_W) ? CNT_W : WIN_CFG_W;
  localparam int CMP_W  = (SEQ_WIDTH > TOTAL_W) ? SEQ_WIDTH : TOTAL_W;

  logic [WIN_CFG_W-1:0]  window_size_q;
  logic [TOTAL_W-1:0]    total_packets_q;
  logic [CNT_W-1:0]      frame_count_q;
  logic [CNT_W-1:0]      read_pos_q;
  logic [CNT_W-1:0]      kept_q;
  logic [CNT_W-1:0]      emit_idx_q;
  logic [SEQ_WIDTH-1:0]  next_seq_q;
  logic [FRAME_W-1:0]    frame_index_q;
  logic                  session_done_q;
  logic                  nak_q;
  logic                  last_q;

  logic [SEQ_WIDTH-1:0]  mem_q [MAX_WINDOW];
  logic [SEQ_WIDTH-1:0]  rd_data_q;

  logic                  out_valid_q;
  logic [PKT_W-1:0]      out_pkt_q;
  logic [FRAME_W-1:0]    out_frame_q;
  logic                  out_last_q;
  logic                  out_fin_q;

  logic [WIN_W-1:0]      win_ext;
  logic [WIN_W-1:0]      win_eff;
  logic                  seq_lt_total;
  logic [CNT_W-1:0]      read_pos_inc;
  logic [CNT_W-1:0]      emit_idx_inc;
  logic [CNT_W-1:0]      rd_sel;
  logic [ADDR_W-1:0]     rd_addr;
  logic [ADDR_W-1:0]     wr_addr;
  logic [SEQ_WIDTH-1:0]  wr_data;
  logic                  wr_en;
  logic                  out_free;

  // Clamp the window to 1..MAX_WINDOW.
  always_comb begin
    win_ext = WIN_W'(window_size_q);
    if (win_ext == '0) begin
      win_eff = WIN_W'(1);
    end else if (win_ext > WIN_W'(MAX_WINDOW)) begin
      win_eff = WIN_W'(MAX_WINDOW);
    end else begin
      win_eff = win_ext;
    end
  end

  assign seq_lt_total = CMP_W'(next_seq_q) < CMP_W'(total_packets_q);
  assign read_pos_inc = read_pos_q + CNT_W'(1);
  assign emit_idx_inc = emit_idx_q + CNT_W'(1);
  assign out_free     = !out_valid_q || out_ready_i;

  always_comb begin
    sts_o.session_open = (frame_count_q != '0) && !session_done_q;
    sts_o.ack_end      = last_q || (read_pos_inc == frame_count_q);
    sts_o.ack_close    = (kept_q == '0) && !nak_q && !seq_lt_total;
    sts_o.refill_more  = (WIN_W'(kept_q) < win_eff) && seq_lt_total;
    sts_o.refill_empty = (kept_q == '0);
    sts_o.emit_last    = (emit_idx_inc == frame_count_q);
    sts_o.out_free     = out_free;
  end

  // Read address: ack lookup, first entry of a new frame, or readout prefetch.
  always_comb begin
    if (cmd_i.ack_rd) begin
      rd_sel = read_pos_q;
    end else if (cmd_i.frame_load) begin
      rd_sel = '0;
    end else if (cmd_i.emit) begin
      rd_sel = emit_idx_inc;
    end else begin
      rd_sel = emit_idx_q;
    end
  end

  assign rd_addr = rd_sel[ADDR_W-1:0];
  assign wr_addr = kept_q[ADDR_W-1:0];
  assign wr_en   = (cmd_i.ack_upd && nak_q) || cmd_i.refill_wr;
  assign wr_data = cmd_i.refill_wr ? next_seq_q : rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_size_q   <= WINDOW_SIZE_RST;
      total_packets_q <= TOTAL_PACKETS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WINDOW_SIZE:   window_size_q   <= cfg_data_i[WIN_CFG_W-1:0];
        CFG_TOTAL_PACKETS: total_packets_q <= cfg_data_i[TOTAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_count_q  <= '0;
      read_pos_q     <= '0;
      kept_q         <= '0;
      emit_idx_q     <= '0;
      next_seq_q     <= '0;
      frame_index_q  <= '0;
      session_done_q <= 1'b0;
      nak_q          <= 1'b0;
      last_q         <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        frame_count_q  <= '0;
        read_pos_q     <= '0;
        kept_q         <= '0;
        next_seq_q     <= '0;
        frame_index_q  <= '0;
        session_done_q <= 1'b0;
      end
      if (cmd_i.ack_rd) begin
        nak_q  <= nak_i;
        last_q <= last_i;
      end
      if (cmd_i.ack_upd) begin
        read_pos_q <= read_pos_inc;
        if (nak_q) begin
          kept_q <= kept_q + CNT_W'(1);
        end
      end
      if (cmd_i.frame_end) begin
        frame_index_q <= frame_index_q + FRAME_W'(1);
      end
      if (cmd_i.refill_wr) begin
        kept_q     <= kept_q + CNT_W'(1);
        next_seq_q <= next_seq_q + SEQ_WIDTH'(1);
      end
      if (cmd_i.frame_load) begin
        frame_count_q <= kept_q;
        read_pos_q    <= '0;
        kept_q        <= '0;
        emit_idx_q    <= '0;
      end
      if (cmd_i.emit) begin
        emit_idx_q <= emit_idx_inc;
      end
      if (cmd_i.close) begin
        session_done_q <= 1'b1;
        frame_count_q  <= '0;
        read_pos_q     <= '0;
        kept_q         <= '0;
      end
    end
  end

  // Result register: load on emit or close, drop once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit || cmd_i.close) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_pkt_q   <= PKT_W'(rd_data_q);
      out_frame_q <= frame_index_q;
      out_last_q  <= sts_o.emit_last;
      out_fin_q   <= 1'b0;
    end else if (cmd_i.close) begin
      out_pkt_q   <= '0;
      out_frame_q <= frame_index_q;
      out_last_q  <= 1'b0;
      out_fin_q   <= 1'b1;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign out_packet_number_o = out_pkt_q;
  assign out_frame_number_o  = out_frame_q;
  assign out_last_of_frame_o = out_last_q;
  assign out_finished_o      = out_fin_q;

endmodule

### sv/srsw_ctrl.sv
// Controller: sequences ack handling, window refill, frame readout and close.
module srsw_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_mode_i,
  output logic                 in_ready_o,
  input  srsw_pkg::srsw_sts_t  sts_i,
  output srsw_pkg::srsw_cmd_t  cmd_o
);
  import srsw_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACK,
    ST_REFILL,
    ST_EMIT,
    ST_FIN
  } state_e;

  state_e state_q;
  state_e state_d;
  logic   accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_mode_i == MODE_START) begin
            cmd_o.start = 1'b1;
            state_d     = ST_REFILL;
          end else if (sts_i.session_open) begin
            cmd_o.ack_rd = 1'b1;
            state_d      = ST_ACK;
          end
        end
      end
      ST_ACK: begin
        cmd_o.ack_upd = 1'b1;
        if (sts_i.ack_end) begin
          cmd_o.frame_end = 1'b1;
          state_d = sts_i.ack_close ? ST_FIN : ST_REFILL;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_REFILL: begin
        if (sts_i.refill_more) begin
          cmd_o.refill_wr = 1'b1;
        end else if (sts_i.refill_empty) begin
          state_d = ST_FIN;
        end else begin
          cmd_o.frame_load = 1'b1;
          state_d          = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.emit_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.close = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### sv/selective_repeat_sender_window_unit.sv
// Selective repeat ARQ sender window, taking input only when idle. An ack entry is read
// there, then applied in the ack state. A start item or a frame-ending ack that does
// not close writes fresh sequence numbers; the frame then leaves one packet per cycle
// while the output is free, via the single buffer read port. A close loads the finished
// result. Reset (async, active low) clears counters and control, sets window 4 and
// total 0; the frame buffer is not cleared and every entry is written before it is read.
`include "assert_macros.svh"

module selective_repeat_sender_window_unit #(
  parameter int MAX_WINDOW = 64,
  parameter int SEQ_WIDTH  = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  srsw_in_if.sink    in_i,
  srsw_out_if.source out_o,
  srsw_cfg_if.sink   cfg_i
);
  import srsw_pkg::*;

  srsw_cmd_t  cmd;
  srsw_sts_t  sts;
  logic [6:0] cmd_ops;

  assign cfg_i.ready = 1'b1;

  // The frame counter bump rides with the ack update, so leave it out here.
  assign cmd_ops = {cmd.start, cmd.ack_rd, cmd.ack_upd, cmd.refill_wr,
                    cmd.frame_load, cmd.emit, cmd.close};

  srsw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_mode_i  (in_i.mode),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  srsw_datapath #(
    .MAX_WINDOW (MAX_WINDOW),
    .SEQ_WIDTH  (SEQ_WIDTH)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_i.valid),
    .cfg_idx_i           (cfg_i.index),
    .cfg_data_i          (cfg_i.data),
    .nak_i               (in_i.nak),
    .last_i              (in_i.last_entry),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .out_ready_i         (out_o.ready),
    .out_valid_o         (out_o.valid),
    .out_packet_number_o (out_o.packet_number),
    .out_frame_number_o  (out_o.frame_number),
    .out_last_of_frame_o (out_o.last_of_frame),
    .out_finished_o      (out_o.finished)
  );

  // At most one datapath operation per cycle.
  `SRSW_ASSERT(a_cmd_onehot, clk_i, rst_ni, $onehot0(cmd_ops),
    "more than one datapath command")
  // An accepted ack in an open session is applied in the following cycle.
  `SRSW_ASSERT_NEXT(a_ack_applied, clk_i, rst_ni,
    in_i.valid && in_i.ready && in_i.mode == MODE_ACK && sts.session_open,
    cmd.ack_upd, "accepted ack not applied")
  // A finished result carries no packet and no frame end marker.
  `SRSW_ASSERT(a_fin_clean, clk_i, rst_ni,
    !(out_o.valid && out_o.finished) ||
    (out_o.last_of_frame == 1'b0 && out_o.packet_number == '0),
    "finished result has packet fields")

endmodule
